/* hw/rtl/rtc_time_registers_assert.svh */
`ifndef RTC_TIME_REGISTERS_ASSERT_SVH
`define RTC_TIME_REGISTERS_ASSERT_SVH

`ifndef SYNTHESIS

`define RTC_TR_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rtc_time_registers: assertion failed");

`define RTC_TR_ASSERT(label, prop) \
    `RTC_TR_ASSERT_CLK(label, aclk, aresetn, prop)

`else

`define RTC_TR_ASSERT_CLK(label, clk, rstn, prop)

`define RTC_TR_ASSERT(label, prop)

`endif

`endif

/* hw/rtl/rtc_tr_pkg.sv */
package rtc_tr_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    localparam logic [3:0] SEL_SEC   = 4'd8;
    localparam logic [3:0] SEL_MIN   = 4'd9;
    localparam logic [3:0] SEL_HOUR  = 4'd10;
    localparam logic [3:0] SEL_DAYLO = 4'd11;
    localparam logic [3:0] SEL_DAYHI = 4'd12;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] reg_select;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [8:0] day;
    } time_t;

    function automatic logic [5:0] mod60(input logic [7:0] d);
        logic [7:0] r;
        r = d;
        if (r >= 8'd240) r = r - 8'd240;
        if (r >= 8'd120) r = r - 8'd120;
        if (r >= 8'd60)  r = r - 8'd60;
        return r[5:0];
    endfunction

    function automatic logic [4:0] mod24(input logic [7:0] d);
        logic [7:0] r;
        r = d;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        return r[4:0];
    endfunction

endpackage

/* hw/rtl/rtc_tr_in_stage.sv */
module rtc_tr_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [3:0]         s_reg_select,
    input  logic [7:0]         s_write_data,
    input  logic               fire,
    output logic               item_valid,
    output rtc_tr_pkg::item_t  item
);

    logic              valid_reg;
    logic              valid_next;
    rtc_tr_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || fire;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.kind       <= rtc_tr_pkg::kind_t'(s_kind);
            item_reg.reg_select <= s_reg_select;
            item_reg.write_data <= s_write_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/rtc_tr_time_core.sv */
module rtc_tr_time_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  rtc_tr_pkg::item_t  item,
    input  logic               out_free,
    output logic               fire,
    output rtc_tr_pkg::time_t  time_now
);

    rtc_tr_pkg::time_t time_reg;
    rtc_tr_pkg::time_t time_next;

    assign fire = item_valid && out_free;

    always_comb begin
        time_next = time_reg;
        if (fire) begin
            case (item.kind)
                rtc_tr_pkg::KIND_TICK: begin
                    if (time_reg.sec != rtc_tr_pkg::SEC_LAST) begin
                        time_next.sec = time_reg.sec + 6'd1;
                    end else begin
                        time_next.sec = 6'd0;
                        if (time_reg.min != rtc_tr_pkg::MIN_LAST) begin
                            time_next.min = time_reg.min + 6'd1;
                        end else begin
                            time_next.min = 6'd0;
                            if (time_reg.hour != rtc_tr_pkg::HOUR_LAST) begin
                                time_next.hour = time_reg.hour + 5'd1;
                            end else begin
                                time_next.hour = 5'd0;
                                time_next.day  = time_reg.day + 9'd1;
                            end
                        end
                    end
                end
                rtc_tr_pkg::KIND_WRITE: begin
                    unique case (item.reg_select)
                        rtc_tr_pkg::SEL_SEC:   time_next.sec  = rtc_tr_pkg::mod60(item.write_data);
                        rtc_tr_pkg::SEL_MIN:   time_next.min  = rtc_tr_pkg::mod60(item.write_data);
                        rtc_tr_pkg::SEL_HOUR:  time_next.hour = rtc_tr_pkg::mod24(item.write_data);
                        rtc_tr_pkg::SEL_DAYLO: time_next.day[7:0] = item.write_data;
                        rtc_tr_pkg::SEL_DAYHI: time_next.day[8]   = item.write_data[0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else begin
            time_reg <= time_next;
        end
    end

    assign time_now = time_reg;

endmodule

/* hw/rtl/rtc_tr_out_stage.sv */
module rtc_tr_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [3:0]         reg_select,
    input  rtc_tr_pkg::time_t  time_now,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_read_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        unique case (reg_select)
            rtc_tr_pkg::SEL_SEC:   data_next = {2'd0, time_now.sec};
            rtc_tr_pkg::SEL_MIN:   data_next = {2'd0, time_now.min};
            rtc_tr_pkg::SEL_HOUR:  data_next = {3'd0, time_now.hour};
            rtc_tr_pkg::SEL_DAYLO: data_next = time_now.day[7:0];
            rtc_tr_pkg::SEL_DAYHI: data_next = {7'd0, time_now.day[8]};
            default:               data_next = 8'd0;
        endcase
    end

    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_read_data = data_reg;

endmodule

/* hw/rtl/rtc_time_registers.sv */
// Real-time clock with seconds, minutes, hours and a 9-bit day count behind five byte
// registers (select 8 seconds, 9 minutes, 10 hours, 11 day low byte, 12 day bit 8). A tick
// beat advances time by one second; a write beat replaces one field (seconds and minutes
// mod 60, hours mod 24); a read beat returns one result beat with the selected field, or 0
// for any other select. Ticks, writes and kind 3 return nothing. A beat can be taken every
// cycle while no read result waits on m_ready: it is registered in the input register,
// then updates the time or loads the result register, so a read result is valid once it
// has passed both registers. While a result waits on m_ready, the next beat, ticks
// included, waits in the input register and s_ready stays low until it is taken.
`include "rtc_time_registers_assert.svh"

module rtc_time_registers (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [3:0] s_reg_select,
    input  logic [7:0] s_write_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);

    logic              item_valid;
    rtc_tr_pkg::item_t item;
    logic              fire;
    logic              out_free;
    logic              load;
    rtc_tr_pkg::time_t time_now;
    logic              time_in_range;
    logic              fire_no_read;
    logic              tick_no_wrap;

    rtc_tr_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_reg_select (s_reg_select),
        .s_write_data (s_write_data),
        .fire         (fire),
        .item_valid   (item_valid),
        .item         (item)
    );

    rtc_tr_time_core u_time_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .fire       (fire),
        .time_now   (time_now)
    );

    assign load = fire && (item.kind == rtc_tr_pkg::KIND_READ);

    rtc_tr_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .reg_select  (item.reg_select),
        .time_now    (time_now),
        .out_free    (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data)
    );

    assign time_in_range = (time_now.sec <= rtc_tr_pkg::SEC_LAST)
                        && (time_now.min <= rtc_tr_pkg::MIN_LAST)
                        && (time_now.hour <= rtc_tr_pkg::HOUR_LAST);
    assign fire_no_read  = fire && (item.kind != rtc_tr_pkg::KIND_READ);
    assign tick_no_wrap  = fire && (item.kind == rtc_tr_pkg::KIND_TICK)
                        && (time_now.sec != rtc_tr_pkg::SEC_LAST);

    `RTC_TR_ASSERT(a_time_in_range, time_in_range)
    `RTC_TR_ASSERT(a_read_gives_beat, load |=> m_valid)
    `RTC_TR_ASSERT(a_other_no_beat, fire_no_read |=> !m_valid)
    `RTC_TR_ASSERT(a_tick_counts, tick_no_wrap |=> (time_now.sec == $past(time_now.sec) + 6'd1))

endmodule

/* tb/rtc_time_registers_checker.sv */
`timescale 1ns / 1ps

module rtc_time_registers_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [3:0] s_reg_select,
    input  logic [7:0] s_write_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_read_data,
    output int         mismatches,
    output int         reads_due
);

    logic [5:0] sec_now;
    logic [5:0] min_now;
    logic [4:0] hour_now;
    logic [8:0] day_now;
    logic [7:0] read_queue[$];
    logic [7:0] want;

    task automatic report_mismatch(input string what);
        $display("%0t rtc checker: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [7:0] field_value(input logic [3:0] sel);
        case (sel)
            rtc_tr_pkg::SEL_SEC:   return {2'b00, sec_now};
            rtc_tr_pkg::SEL_MIN:   return {2'b00, min_now};
            rtc_tr_pkg::SEL_HOUR:  return {3'b000, hour_now};
            rtc_tr_pkg::SEL_DAYLO: return day_now[7:0];
            rtc_tr_pkg::SEL_DAYHI: return {7'b0000000, day_now[8]};
            default:               return 8'h00;
        endcase
    endfunction

    task automatic advance_second();
        if (sec_now < rtc_tr_pkg::SEC_LAST) begin
            sec_now = sec_now + 6'd1;
        end else begin
            sec_now = '0;
            if (min_now < rtc_tr_pkg::MIN_LAST) begin
                min_now = min_now + 6'd1;
            end else begin
                min_now = '0;
                if (hour_now < rtc_tr_pkg::HOUR_LAST) begin
                    hour_now = hour_now + 5'd1;
                end else begin
                    hour_now = '0;
                    day_now = day_now + 9'd1;
                end
            end
        end
    endtask

    task automatic store_field(input logic [3:0] sel, input logic [7:0] data);
        int value;
        value = data;
        case (sel)
            rtc_tr_pkg::SEL_SEC:   sec_now = 6'(value % 60);
            rtc_tr_pkg::SEL_MIN:   min_now = 6'(value % 60);
            rtc_tr_pkg::SEL_HOUR:  hour_now = 5'(value % 24);
            rtc_tr_pkg::SEL_DAYLO: day_now[7:0] = data;
            rtc_tr_pkg::SEL_DAYHI: day_now[8] = data[0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sec_now = '0;
            min_now = '0;
            hour_now = '0;
            day_now = '0;
            read_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (read_queue.size() == 0) begin
                    report_mismatch($sformatf("read beat %0d with no read pending",
                                              m_read_data));
                end else begin
                    want = read_queue.pop_front();
                    if (m_read_data !== want) begin
                        report_mismatch($sformatf("read_data %0d, want %0d",
                                                  m_read_data, want));
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_kind)
                    rtc_tr_pkg::KIND_TICK:  advance_second();
                    rtc_tr_pkg::KIND_READ:  read_queue.push_back(field_value(s_reg_select));
                    rtc_tr_pkg::KIND_WRITE: store_field(s_reg_select, s_write_data);
                    default: ;
                endcase
            end
        end
        reads_due = read_queue.size();
    end

endmodule

/* tb/rtc_time_registers_tb.sv */
`timescale 1ns / 1ps

module rtc_time_registers_tb;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_BEATS = 1900;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind = rtc_tr_pkg::KIND_TICK;
    logic [3:0] s_reg_select = 4'd0;
    logic [7:0] s_write_data = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;

    int mismatches;
    int reads_due;
    int beats_sent = 0;
    int ready_hold = 0;
    bit calm = 1'b0;

    always #5 aclk = ~aclk;

    rtc_time_registers u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_reg_select (s_reg_select),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data)
    );

    rtc_time_registers_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_reg_select (s_reg_select),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .mismatches   (mismatches),
        .reads_due    (reads_due)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] near_value(input int last);
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return 8'(last - $urandom_range(0, 2));
    endfunction

    function automatic logic [3:0] inert_select();
        int s;
        s = $urandom_range(0, 10);
        return 4'((s < 8) ? s : s + 5);
    endfunction

    // hold each beat until accepted; drop valid only for a gap
    task automatic send_beat(input logic [1:0] k, input logic [3:0] sel,
                             input logic [7:0] data);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_reg_select <= sel;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (k != KIND_SPARE) beats_sent++;
    endtask

    task automatic drain_reads();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (reads_due != 0) @(negedge aclk);
    endtask

    task automatic read_all_fields();
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_SEC, 8'($urandom));
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_MIN, 8'($urandom));
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_HOUR, 8'($urandom));
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_DAYLO, 8'($urandom));
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_DAYHI, 8'($urandom));
    endtask

    task automatic run_rollover();
        int n_ticks;
        if ($urandom_range(0, 1)) begin
            send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_SEC,
                      near_value(rtc_tr_pkg::SEC_LAST));
        end
        if ($urandom_range(0, 1)) begin
            send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_MIN,
                      near_value(rtc_tr_pkg::MIN_LAST));
        end
        if ($urandom_range(0, 1)) begin
            send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_HOUR,
                      near_value(rtc_tr_pkg::HOUR_LAST));
        end
        if ($urandom_range(0, 2) == 0) begin
            send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_DAYLO, near_value(255));
        end
        if ($urandom_range(0, 2) == 0) begin
            send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_DAYHI, 8'($urandom));
        end
        n_ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 8);
        repeat (n_ticks) begin
            send_beat(rtc_tr_pkg::KIND_TICK, 4'($urandom), 8'($urandom));
            if ($urandom_range(0, 5) == 0) begin
                send_beat(rtc_tr_pkg::KIND_READ, 4'(rtc_tr_pkg::SEL_SEC + $urandom_range(0, 4)),
                          8'($urandom));
            end
        end
        read_all_fields();
    endtask

    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            m_ready <= 1'b1;
            ready_hold <= calm ? 0 : $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b0;
            ready_hold <= pick_gap();
        end
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int rand_start;
        int r;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_SEC, 8'h00);
        send_beat(rtc_tr_pkg::KIND_TICK, rtc_tr_pkg::SEL_SEC, 8'h00);
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_SEC, 8'hff);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_SEC, 8'hff);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_MIN, 8'd59);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_HOUR, 8'hff);
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_HOUR, 8'h00);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_HOUR, 8'd23);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_DAYLO, 8'hff);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_DAYHI, 8'hff);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_SEC, 8'd59);
        send_beat(rtc_tr_pkg::KIND_TICK, 4'hf, 8'hff);
        read_all_fields();
        send_beat(rtc_tr_pkg::KIND_WRITE, 4'd0, 8'hff);
        send_beat(rtc_tr_pkg::KIND_READ, 4'hf, 8'hff);
        send_beat(KIND_SPARE, rtc_tr_pkg::SEL_SEC, 8'haa);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_DAYHI, 8'hfe);
        send_beat(rtc_tr_pkg::KIND_WRITE, rtc_tr_pkg::SEL_MIN, 8'd60);
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_MIN, 8'h00);
        send_beat(rtc_tr_pkg::KIND_READ, rtc_tr_pkg::SEL_DAYHI, 8'h00);
        drain_reads();

        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS) begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
                run_rollover();
            end else if (r < 16) begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(2'($urandom), 4'($urandom), 8'($urandom));
                end
            end else if (r == 16) begin
                send_beat($urandom_range(0, 1) ? rtc_tr_pkg::KIND_READ : rtc_tr_pkg::KIND_WRITE,
                          inert_select(), 8'($urandom));
            end else if (r == 17) begin
                drain_reads();
            end else if (r == 18) begin
                calm = !calm;
            end else begin
                send_beat(KIND_SPARE, 4'($urandom), 8'($urandom));
            end
        end
        calm = 1'b0;

        drain_reads();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && reads_due == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
